// File: src/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 24;

    localparam int OP_W       = 3;
    localparam int CH_W       = 8;
    localparam int COLUMN_W   = 7;
    localparam int ROW_IN_W   = 5;
    localparam int POS_W      = 11;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CH_W + ATTR_W;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [CH_W-1:0]   SPACE_CHAR   = 8'd32;
    localparam logic [CH_W-1:0]   NEWLINE_CHAR = 8'd10;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 3'd0,
        OP_RIGHT = 3'd1,
        OP_LEFT  = 3'd2,
        OP_SET   = 3'd3,
        OP_CLEAR = 3'd4,
        OP_READ  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        CUR_NONE,
        CUR_INC,
        CUR_DEC,
        CUR_NEWLINE,
        CUR_SET
    } cur_op_t;

    typedef struct packed {
        logic    load;
        cur_op_t op;
    } cur_req_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_SCROLL,
        S_FILL,
        S_READ,
        S_DONE
    } state_t;

endpackage

// File: src/text_console_cell_writer.sv
`timescale 1ns / 1ps

// channel    dir  handshake           payload
// s_axis     in   s_tvalid/s_tready   s_tuser operation, s_tdata ch, column, row
// m_axis     out  m_tvalid/m_tready   m_tdata cursor_position, cell_char, cell_attr, scrolled
// cfg        in   cfg_wen             cfg_wdata text_attribute
//
// put char, cursor moves and set position go through the decode and done states, read cell
// also through a read state; a scroll adds a scroll sweep and a bottom row fill, clear a fill,
// each a one cell per cycle sweep through the single write port of the cell memory
// after reset a clearing pass over all ROWS*COLUMNS cells runs with s_tready low
// a request is taken while an earlier result still waits in the output register
// a stalled m_tready holds the next result in its final state

module text_console_cell_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tcw_pkg::IN_DATA_W-1:0]     s_tdata,   // ch, column, row
    input  logic [tcw_pkg::OP_W-1:0]          s_tuser,   // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tcw_pkg::OUT_DATA_W-1:0]    m_tdata,   // cursor_position, cell_char,
                                                         // cell_attr, scrolled
    input  logic                              cfg_wen,
    input  logic [tcw_pkg::ATTR_W-1:0]        cfg_wdata
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int IDX_W   = $clog2(CELLS);
    localparam int BOTTOM  = CELLS - COLUMNS;
    localparam int BOTTOM_POS = BOTTOM % (1 << tcw_pkg::POS_W);
    localparam int CH_LO   = 0;
    localparam int COL_LO  = CH_LO + tcw_pkg::CH_W;
    localparam int ROW_LO  = COL_LO + tcw_pkg::COLUMN_W;
    localparam int OUT_USED = tcw_pkg::POS_W + 2 * tcw_pkg::CH_W + 1;

    tcw_pkg::state_t   state_reg, state_next;
    tcw_pkg::cur_req_t cur_req;

    logic [IDX_W-1:0]                cnt_reg, cnt_next;
    logic [IDX_W-1:0]                wr_addr_reg;
    logic [tcw_pkg::OP_W-1:0]        op_reg;
    logic [tcw_pkg::CH_W-1:0]        ch_reg;
    logic [tcw_pkg::ATTR_W-1:0]      attr_reg;
    logic [tcw_pkg::CH_W-1:0]        res_char_reg, res_char_next;
    logic [tcw_pkg::ATTR_W-1:0]      res_attr_reg, res_attr_next;
    logic                            scr_reg, scr_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [tcw_pkg::POS_W-1:0]       out_pos_reg;
    logic [tcw_pkg::CH_W-1:0]        out_char_reg;
    logic [tcw_pkg::ATTR_W-1:0]      out_attr_reg;
    logic                            out_scr_reg;
    logic                            out_load;

    logic                            accept;
    logic [IDX_W:0]                  scroll_sum;
    logic [IDX_W-1:0]                cur_pos;
    logic [IDX_W-1:0]                tgt_idx;
    logic                            cur_wrap;

    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]                ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]      ram_rdata;

    assign s_tready   = (state_reg == tcw_pkg::S_IDLE);
    assign accept     = s_tvalid & s_tready;
    assign scroll_sum = {1'b0, cnt_reg} + (IDX_W + 1)'(COLUMNS);

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (cur_req),
        .column_in (s_tdata[ROW_LO-1:COL_LO]),
        .row_in    (s_tdata[ROW_LO+tcw_pkg::ROW_IN_W-1:ROW_LO]),
        .pos       (cur_pos),
        .tgt_idx   (tgt_idx),
        .wrap      (cur_wrap)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::S_INIT:
            begin
                if (cnt_reg == IDX_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::S_IDLE;
                end
            end
            tcw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = tcw_pkg::S_DECODE;
                end
            end
            tcw_pkg::S_DECODE:
            begin
                case (op_reg)
                    tcw_pkg::OP_PUT, tcw_pkg::OP_RIGHT:
                        state_next = cur_wrap ? tcw_pkg::S_SCROLL : tcw_pkg::S_DONE;
                    tcw_pkg::OP_CLEAR:
                        state_next = tcw_pkg::S_FILL;
                    tcw_pkg::OP_READ:
                        state_next = tcw_pkg::S_READ;
                    default:
                        state_next = tcw_pkg::S_DONE;
                endcase
            end
            tcw_pkg::S_SCROLL:
            begin
                if (cnt_reg == IDX_W'(BOTTOM))
                begin
                    state_next = tcw_pkg::S_FILL;
                end
            end
            tcw_pkg::S_FILL:
            begin
                if (cnt_reg == IDX_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::S_DONE;
                end
            end
            tcw_pkg::S_READ:
            begin
                state_next = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = tcw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::S_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb
    begin
        cur_req.load  = accept;
        cur_req.op    = tcw_pkg::CUR_NONE;
        cnt_next      = cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg;
        ram_wdata     = {attr_reg, tcw_pkg::SPACE_CHAR};
        ram_raddr     = scroll_sum[IDX_W-1:0];
        res_char_next = res_char_reg;
        res_attr_next = res_attr_reg;
        scr_next      = scr_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        out_load      = 1'b0;
        case (state_reg)
            tcw_pkg::S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::SPACE_CHAR};
                cnt_next  = cnt_reg + IDX_W'(1);
            end
            tcw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_char_next = '0;
                    res_attr_next = '0;
                    scr_next      = 1'b0;
                end
            end
            tcw_pkg::S_DECODE:
            begin
                ram_raddr = tgt_idx;
                cnt_next  = '0;
                case (op_reg)
                    tcw_pkg::OP_PUT:
                    begin
                        if (ch_reg == tcw_pkg::NEWLINE_CHAR)
                        begin
                            cur_req.op = tcw_pkg::CUR_NEWLINE;
                        end
                        else
                        begin
                            cur_req.op = tcw_pkg::CUR_INC;
                            ram_we     = 1'b1;
                            ram_waddr  = cur_pos;
                            ram_wdata  = {attr_reg, ch_reg};
                        end
                        scr_next = cur_wrap;
                    end
                    tcw_pkg::OP_RIGHT:
                    begin
                        cur_req.op = tcw_pkg::CUR_INC;
                        scr_next   = cur_wrap;
                    end
                    tcw_pkg::OP_LEFT:
                        cur_req.op = tcw_pkg::CUR_DEC;
                    tcw_pkg::OP_SET:
                        cur_req.op = tcw_pkg::CUR_SET;
                    default:
                        cur_req.op = tcw_pkg::CUR_NONE;
                endcase
            end
            tcw_pkg::S_SCROLL:
            begin
                // read one row below, write the cell read in the cycle before
                ram_we    = (cnt_reg != '0);
                ram_waddr = wr_addr_reg;
                ram_wdata = ram_rdata;
                if (cnt_reg != IDX_W'(BOTTOM))
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            tcw_pkg::S_FILL:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + IDX_W'(1);
            end
            tcw_pkg::S_READ:
            begin
                res_char_next = ram_rdata[tcw_pkg::CH_W-1:0];
                res_attr_next = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CH_W];
            end
            tcw_pkg::S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_load      = 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tcw_pkg::S_INIT;
            cnt_reg      <= '0;
            attr_reg     <= tcw_pkg::ATTR_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= cnt_reg;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
        scr_reg      <= scr_next;
        if (accept)
        begin
            op_reg <= s_tuser;
            ch_reg <= s_tdata[COL_LO-1:CH_LO];
        end
        if (out_load)
        begin
            out_pos_reg  <= tcw_pkg::POS_W'(cur_pos);
            out_char_reg <= res_char_reg;
            out_attr_reg <= res_attr_reg;
            out_scr_reg  <= scr_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(tcw_pkg::OUT_DATA_W - OUT_USED){1'b0}},
                       out_scr_reg, out_attr_reg, out_char_reg, out_pos_reg};

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cur_pos) < CELLS)
        else $error("cursor left the screen");

    // cell writes stay inside the memory
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> int'(ram_waddr) < CELLS)
        else $error("cell write out of range");

    // a scrolled result leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_scr_reg) |-> int'(out_pos_reg) == BOTTOM_POS)
        else $error("scroll left cursor off the bottom row");

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request taken while busy");

endmodule

// File: src/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int  WIDTH  = 16,
    parameter int  DEPTH  = 1920,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/tcw_cursor.sv
`timescale 1ns / 1ps

module tcw_cursor #(
    parameter int  COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int  ROWS    = tcw_pkg::ROWS_DEF,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int IDX_W   = $clog2(CELLS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcw_pkg::cur_req_t             req,
    input  logic [tcw_pkg::COLUMN_W-1:0]  column_in,
    input  logic [tcw_pkg::ROW_IN_W-1:0]  row_in,
    output logic [IDX_W-1:0]              pos,
    output logic [IDX_W-1:0]              tgt_idx,
    output logic                          wrap
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BOTTOM = CELLS - COLUMNS;

    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [COL_W-1:0] tgt_col_reg;
    logic [ROW_W-1:0] tgt_row_reg;
    logic [IDX_W-1:0] tgt_base_reg;
    logic [IDX_W-1:0] tgt_idx_reg;

    logic [COL_W-1:0] col_cl;
    logic [ROW_W-1:0] row_cl;
    logic [IDX_W-1:0] base_cl;

    // clamp requested cell to the screen
    always_comb
    begin
        col_cl  = (int'(column_in) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : COL_W'(column_in);
        row_cl  = (int'(row_in) > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(row_in);
        base_cl = IDX_W'(row_cl) * IDX_W'(COLUMNS);
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            tgt_col_reg  <= col_cl;
            tgt_row_reg  <= row_cl;
            tgt_base_reg <= base_cl;
            tgt_idx_reg  <= base_cl + IDX_W'(col_cl);
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        base_next = base_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        wrap      = 1'b0;
        case (req.op)
            tcw_pkg::CUR_INC:
            begin
                if (pos_reg == IDX_W'(CELLS - 1))
                begin
                    wrap     = 1'b1;
                    pos_next = IDX_W'(BOTTOM);
                    col_next = '0;
                end
                else if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    col_next  = '0;
                    row_next  = row_reg + ROW_W'(1);
                    base_next = base_reg + IDX_W'(COLUMNS);
                    pos_next  = pos_reg + IDX_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                    pos_next = pos_reg + IDX_W'(1);
                end
            end
            tcw_pkg::CUR_NEWLINE:
            begin
                col_next = '0;
                if (row_reg == ROW_W'(ROWS - 1))
                begin
                    wrap     = 1'b1;
                    pos_next = IDX_W'(BOTTOM);
                end
                else
                begin
                    row_next  = row_reg + ROW_W'(1);
                    base_next = base_reg + IDX_W'(COLUMNS);
                    pos_next  = base_reg + IDX_W'(COLUMNS);
                end
            end
            tcw_pkg::CUR_DEC:
            begin
                if (pos_reg != '0)
                begin
                    pos_next = pos_reg - IDX_W'(1);
                    if (col_reg == '0)
                    begin
                        col_next  = COL_W'(COLUMNS - 1);
                        row_next  = row_reg - ROW_W'(1);
                        base_next = base_reg - IDX_W'(COLUMNS);
                    end
                    else
                    begin
                        col_next = col_reg - COL_W'(1);
                    end
                end
            end
            tcw_pkg::CUR_SET:
            begin
                col_next  = tgt_col_reg;
                row_next  = tgt_row_reg;
                base_next = tgt_base_reg;
                pos_next  = tgt_idx_reg;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            base_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            base_reg <= base_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    assign pos     = pos_reg;
    assign tgt_idx = tgt_idx_reg;

endmodule
